// File: rtl/gtpce_pkg.sv
`timescale 1ns / 1ps

package gtpce_pkg;

  // longest datagram that is counted, bytes past it are dropped
  localparam int MaxDatagram = 4096;
  localparam int CountW      = $clog2(MaxDatagram + 1);
  localparam int StoreDepth  = 12;
  localparam int StoreIdxW   = $clog2(StoreDepth);
  localparam int PcW         = 6;
  // width of the length compares, announced length plus 8 without overflow
  localparam int LenW        = 17;

  localparam logic [7:0] TypeEchoReq       = 8'd1;
  localparam logic [7:0] TypeEchoRsp       = 8'd2;
  localparam logic [7:0] V1IeRecovery      = 8'd14;
  localparam logic [7:0] V2IeRecovery      = 8'd3;
  localparam logic [7:0] V2IeNodeFeatures  = 8'd152;

  // register indexes of the configuration port
  localparam logic CfgRecovery     = 1'b0;
  localparam logic CfgNodeFeatures = 1'b1;

  typedef enum logic [2:0] {
    STAT_RESPONSE    = 3'd0,
    STAT_IGNORED     = 3'd1,
    STAT_SHORT_HDR   = 3'd2,
    STAT_SHORT_LEN   = 3'd3,
    STAT_GTP_PRIME   = 3'd4,
    STAT_PIGGYBACK   = 3'd5,
    STAT_ECHO_T      = 3'd6,
    STAT_BAD_VERSION = 3'd7
  } status_t;

  // byte source of one control word
  typedef enum logic [2:0] {
    SRC_HDR,
    SRC_IMM,
    SRC_PLEN,
    SRC_REC,
    SRC_NF
  } src_t;

  typedef enum logic [1:0] {
    END_NONE,
    END_ALWAYS,
    END_IF_NF_ZERO
  } end_t;

  typedef struct packed {
    src_t           src;
    logic [7:0]     imm;      // constant byte, or header index in its low bits
    end_t           endc;
    logic           jmp_short; // jump when the v1 header has 8 bytes
    logic [PcW-1:0] target;
  } ucode_t;

  // work handed from the header checks to the sequencer
  typedef struct packed {
    logic [PcW-1:0] start_pc;
    status_t        status;
    logic [7:0]     plen;
    logic           ext_hdr;
  } job_t;

  localparam logic [PcW-1:0] PcStatus = 6'd0;
  localparam logic [PcW-1:0] PcV1     = 6'd1;
  localparam logic [PcW-1:0] PcV1Tail = 6'd13;
  localparam logic [PcW-1:0] PcV2     = 6'd15;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t cw;
    cw = '{SRC_IMM, 8'd0, END_ALWAYS, 1'b0, PcStatus};
    unique case (pc)
      // single status item
      6'd0:  cw = '{SRC_IMM, 8'd0,             END_ALWAYS,     1'b0, PcStatus};
      // v1 echo response
      6'd1:  cw = '{SRC_HDR, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd2:  cw = '{SRC_IMM, TypeEchoRsp,      END_NONE,       1'b0, PcStatus};
      6'd3:  cw = '{SRC_IMM, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd4:  cw = '{SRC_PLEN, 8'd0,            END_NONE,       1'b0, PcStatus};
      6'd5:  cw = '{SRC_HDR, 8'd4,             END_NONE,       1'b0, PcStatus};
      6'd6:  cw = '{SRC_HDR, 8'd5,             END_NONE,       1'b0, PcStatus};
      6'd7:  cw = '{SRC_HDR, 8'd6,             END_NONE,       1'b0, PcStatus};
      6'd8:  cw = '{SRC_HDR, 8'd7,             END_NONE,       1'b1, PcV1Tail};
      6'd9:  cw = '{SRC_HDR, 8'd8,             END_NONE,       1'b0, PcStatus};
      6'd10: cw = '{SRC_HDR, 8'd9,             END_NONE,       1'b0, PcStatus};
      6'd11: cw = '{SRC_HDR, 8'd10,            END_NONE,       1'b0, PcStatus};
      6'd12: cw = '{SRC_HDR, 8'd11,            END_NONE,       1'b0, PcStatus};
      6'd13: cw = '{SRC_IMM, V1IeRecovery,     END_NONE,       1'b0, PcStatus};
      6'd14: cw = '{SRC_REC, 8'd0,             END_ALWAYS,     1'b0, PcStatus};
      // v2 echo response
      6'd15: cw = '{SRC_HDR, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd16: cw = '{SRC_IMM, TypeEchoRsp,      END_NONE,       1'b0, PcStatus};
      6'd17: cw = '{SRC_IMM, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd18: cw = '{SRC_PLEN, 8'd0,            END_NONE,       1'b0, PcStatus};
      6'd19: cw = '{SRC_HDR, 8'd4,             END_NONE,       1'b0, PcStatus};
      6'd20: cw = '{SRC_HDR, 8'd5,             END_NONE,       1'b0, PcStatus};
      6'd21: cw = '{SRC_HDR, 8'd6,             END_NONE,       1'b0, PcStatus};
      6'd22: cw = '{SRC_HDR, 8'd7,             END_NONE,       1'b0, PcStatus};
      6'd23: cw = '{SRC_IMM, V2IeRecovery,     END_NONE,       1'b0, PcStatus};
      6'd24: cw = '{SRC_IMM, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd25: cw = '{SRC_IMM, 8'd1,             END_NONE,       1'b0, PcStatus};
      6'd26: cw = '{SRC_IMM, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd27: cw = '{SRC_REC, 8'd0,             END_IF_NF_ZERO, 1'b0, PcStatus};
      6'd28: cw = '{SRC_IMM, V2IeNodeFeatures, END_NONE,       1'b0, PcStatus};
      6'd29: cw = '{SRC_IMM, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd30: cw = '{SRC_IMM, 8'd1,             END_NONE,       1'b0, PcStatus};
      6'd31: cw = '{SRC_IMM, 8'd0,             END_NONE,       1'b0, PcStatus};
      6'd32: cw = '{SRC_NF,  8'd0,             END_ALWAYS,     1'b0, PcStatus};
      default: cw = '{SRC_IMM, 8'd0,           END_ALWAYS,     1'b0, PcStatus};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/gtpce_seq.sv
`timescale 1ns / 1ps

module gtpce_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  gtpce_pkg::job_t                job,
  input  logic [7:0]                     recovery,
  input  logic [7:0]                     nf_mask,
  input  logic [7:0]                     hdr_byte,
  output logic [gtpce_pkg::StoreIdxW-1:0] hdr_idx,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  output logic [2:0]                     out_status
);
  import gtpce_pkg::*;

  typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_t;

  sq_state_t      state_r;
  logic [PcW-1:0] pc_r;
  job_t           job_r;
  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;
  logic [2:0]     out_status_r;

  ucode_t     cw;
  logic [7:0] byte_sel;
  logic       step_end;
  logic       can_load;
  logic       load;

  assign cw      = ucode_rom(pc_r);
  assign hdr_idx = cw.imm[StoreIdxW-1:0];

  always_comb begin
    unique case (cw.src)
      SRC_HDR:  byte_sel = hdr_byte;
      SRC_IMM:  byte_sel = cw.imm;
      SRC_PLEN: byte_sel = job_r.plen;
      SRC_REC:  byte_sel = recovery;
      SRC_NF:   byte_sel = nf_mask;
      default:  byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    unique case (cw.endc)
      END_NONE:       step_end = 1'b0;
      END_ALWAYS:     step_end = 1'b1;
      END_IF_NF_ZERO: step_end = (nf_mask == 8'd0);
      default:        step_end = 1'b1;
    endcase
  end

  assign can_load = !out_valid_r || !out_stall;
  assign load     = (state_r == SQ_RUN) && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      pc_r        <= PcStatus;
      out_valid_r <= 1'b0;
    end else begin
      // output register fills on a step, drains when taken
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        SQ_IDLE: begin
          if (start) begin
            state_r <= SQ_RUN;
            pc_r    <= job.start_pc;
            job_r   <= job;
          end
        end
        SQ_RUN: begin
          if (load) begin
            out_byte_r   <= byte_sel;
            out_last_r   <= step_end;
            out_status_r <= job_r.status;
            if (step_end) begin
              state_r <= SQ_IDLE;
            end else if (cw.jmp_short && !job_r.ext_hdr) begin
              pc_r <= cw.target;
            end else begin
              pc_r <= pc_r + 1'b1;
            end
          end
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

  assign busy       = (state_r == SQ_RUN);
  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

// File: rtl/gtp_control_echo_responder_core.sv
`timescale 1ns / 1ps

// GTP-C echo responder. A received datagram enters one byte per cycle on the
// in_ channel while in_stall is low, in_last marking its final byte; the first
// 12 bytes are kept and the length is counted, saturating at 4096. The cycle
// after the last byte the header checks run (version, header size, announced
// length, GTP' for v1, piggyback and T for v2) and a microcoded sequencer then
// emits the result one item per cycle while out_stall is low: a single status
// item, or an echo response of 10 or 14 items (v1, by the S/PN/E flags) or 13
// or 18 items (v2, by the node features mask). Input is stalled from the last
// byte until the sequencer has loaded its final item into the output register,
// the sequencer stepping one control word a cycle when the output is not stalled.
// recovery_counter is register 0 and the node features mask register 1; write
// them only while the block is idle.

module gtp_control_echo_responder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_last,
  output logic [2:0] out_status
);
  import gtpce_pkg::*;

  typedef enum logic {S_RECV, S_DECIDE} rx_state_t;

  rx_state_t         state_r;
  logic [CountW-1:0] count_r;
  logic [CountW-1:0] len_r;
  logic [7:0]        recovery_r;
  logic [7:0]        nf_mask_r;
  logic [7:0]        hdr_r [StoreDepth];

  logic                 in_acc;
  logic [CountW-1:0]    count_inc;
  logic                 start;
  job_t                 job;
  logic                 seq_busy;
  logic [StoreIdxW-1:0] hdr_idx;
  logic [7:0]           hdr_byte;

  // header check inputs
  logic [2:0]      version;
  logic [LenW-1:0] len_ext;
  logic [LenW-1:0] ann_ext;
  logic            v1_ext;
  logic [LenW-1:0] v1_hdr;
  logic [LenW-1:0] v2_hdr;
  logic            v2_t;

  assign in_stall = (state_r == S_DECIDE) || seq_busy;
  assign in_acc   = in_valid && !in_stall;
  assign start    = (state_r == S_DECIDE);

  // saturating count, bytes past the limit are dropped
  assign count_inc = (count_r < CountW'(MaxDatagram)) ? count_r + 1'b1 : count_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recovery_r <= 8'd0;
      nf_mask_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRecovery:     recovery_r <= cfg_data;
        CfgNodeFeatures: nf_mask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // receive control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
      count_r <= '0;
      len_r   <= '0;
    end else begin
      unique case (state_r)
        S_RECV: begin
          if (in_acc) begin
            if (in_last) begin
              len_r   <= count_inc;
              count_r <= '0;
              state_r <= S_DECIDE;
            end else begin
              count_r <= count_inc;
            end
          end
        end
        S_DECIDE: state_r <= S_RECV;
        default:  state_r <= S_RECV;
      endcase
    end
  end

  // header store, no reset: only bytes of the current datagram are read
  always_ff @(posedge clk) begin
    if (in_acc && (count_r < CountW'(StoreDepth))) begin
      hdr_r[count_r[StoreIdxW-1:0]] <= in_data_byte;
    end
  end

  assign hdr_byte = hdr_r[hdr_idx];

  // header checks, in the cycle after the last byte
  assign version = hdr_r[0][7:5];
  assign len_ext = LenW'(len_r);
  assign ann_ext = {1'b0, hdr_r[2], hdr_r[3]};
  assign v1_ext  = |hdr_r[0][2:0];
  assign v1_hdr  = v1_ext ? LenW'(12) : LenW'(8);
  assign v2_t    = hdr_r[0][3];
  assign v2_hdr  = v2_t ? LenW'(12) : LenW'(8);

  always_comb begin
    job.start_pc = PcStatus;
    job.status   = STAT_BAD_VERSION;
    job.plen     = 8'd0;
    job.ext_hdr  = v1_ext;
    if (version == 3'd1) begin
      if (len_ext < v1_hdr) begin
        job.status = STAT_SHORT_HDR;
      end else if (len_ext < ann_ext + LenW'(8)) begin
        job.status = STAT_SHORT_LEN;
      end else if (!hdr_r[0][4]) begin
        job.status = STAT_GTP_PRIME;
      end else if (hdr_r[1] != TypeEchoReq) begin
        job.status = STAT_IGNORED;
      end else begin
        job.status   = STAT_RESPONSE;
        job.start_pc = PcV1;
        // header size plus recovery element, less the fixed 8 bytes
        job.plen     = v1_ext ? 8'd6 : 8'd2;
      end
    end else if (version == 3'd2) begin
      if (hdr_r[0][4]) begin
        job.status = STAT_PIGGYBACK;
      end else if (len_ext < v2_hdr) begin
        job.status = STAT_SHORT_HDR;
      end else if (len_ext < ann_ext + LenW'(4)) begin
        job.status = STAT_SHORT_LEN;
      end else if (hdr_r[1] != TypeEchoReq) begin
        job.status = STAT_IGNORED;
      end else if (v2_t) begin
        job.status = STAT_ECHO_T;
      end else begin
        job.status   = STAT_RESPONSE;
        job.start_pc = PcV2;
        // response size less 4: 13 or 18 bytes
        job.plen     = (nf_mask_r != 8'd0) ? 8'd14 : 8'd9;
      end
    end
  end

  gtpce_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .job        (job),
    .recovery   (recovery_r),
    .nf_mask    (nf_mask_r),
    .hdr_byte   (hdr_byte),
    .hdr_idx    (hdr_idx),
    .busy       (seq_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_out_byte),
    .out_last   (out_out_last),
    .out_status (out_status)
  );

  // no byte is taken while a result is being sequenced
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_busy |-> in_stall)
    else $error("input accepted while sequencer busy");

  // the checks never hand work to a running sequencer
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !seq_busy)
    else $error("sequencer started while busy");

  // the last byte is followed by the check cycle
  a_last_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> start)
    else $error("check cycle missing after last byte");

  // a status item is a single zero-byte final item
  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_RESPONSE)) |-> (out_out_last && (out_out_byte == 8'd0)))
    else $error("malformed status item");

endmodule
